// ===== rtl/rfb_pkg.sv =====
// Shared constants, types and geometry helpers for the rotated frame reader.
// Used by every module of the block; depends on nothing.
package rfb_pkg;

   localparam int PANEL_WIDTH  = 800;
   localparam int PANEL_HEIGHT = 480;
   localparam int FB_STRIDE    = (PANEL_WIDTH + 7) / 8;
   localparam int FB_DEPTH     = FB_STRIDE * PANEL_HEIGHT;
   localparam int ADDR_W       = $clog2(FB_DEPTH);

   // Logical coordinates must hold either panel dimension and a full column byte index.
   localparam int MAX_DIM  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int CW       = (DIM_W > 10) ? DIM_W : 10;

   // Aligned BMP row length in bytes for each logical width.
   localparam int ALIGN_PORTRAIT  = (((PANEL_HEIGHT + 7) / 8) + 3) / 4 * 4;
   localparam int ALIGN_LANDSCAPE = (((PANEL_WIDTH + 7) / 8) + 3) / 4 * 4;

   localparam logic [7:0] WHITE_BYTE = 8'hFF;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] ORIENT_PORTRAIT     = 2'd0;
   localparam logic [1:0] ORIENT_LANDSCAPE_CW = 2'd1;
   localparam logic [1:0] ORIENT_PORTRAIT_INV = 2'd2;
   localparam logic [1:0] ORIENT_LANDSCAPE    = 2'd3;
   localparam logic [1:0] ORIENT_RESET        = ORIENT_LANDSCAPE;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              wr_ok;
      logic              oor;
      logic [CW-1:0]     y;
      logic [6:0]        col_byte;
      logic [1:0]        orient;
   } entry_type;

   // Logical width of the image under an orientation.
   function automatic logic [CW-1:0] logical_width(input logic [1:0] orient);
      logical_width = orient[0] ? CW'(PANEL_WIDTH) : CW'(PANEL_HEIGHT);
   endfunction

   function automatic logic [CW-1:0] logical_height(input logic [1:0] orient);
      logical_height = orient[0] ? CW'(PANEL_HEIGHT) : CW'(PANEL_WIDTH);
   endfunction

endpackage

// ===== rtl/rotated_framebuffer_to_bmp_rows.sv =====
// Rotated 1 bpp frame store read back as BMP pixel-array bytes.
// Writes are handled straight from idle in the back end; a read request walks its eight pixels through
// one frame-store read port, one per cycle, and its result is registered once the last pixel
// has passed the read port; no new entry is taken meanwhile. Out-of-range reads give a white byte.
// Reset (synchronous) empties the queue and result register and sets orientation to 3;
// frame contents are not cleared and hold no meaning until written.
module rotated_framebuffer_to_bmp_rows (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // frame_addr[15:0], frame_byte[23:16], bmp_row[33:24],
                                    // bmp_col_byte[40:34], zero [47:41]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_byte
   output logic        rsp_tuser,   // out_of_range
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic [1:0]          orient_ff, orient_in;
   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                head_valid;
   rfb_pkg::entry_type  push_entry;
   rfb_pkg::entry_type  head_entry;

   assign orient_in = csr_wr_en ? csr_wr_data : orient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= rfb_pkg::ORIENT_RESET;
      end else begin
         orient_ff <= orient_in;
      end
   end

   rfb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .orient     (orient_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   rfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/rfb_front.sv =====
// Front end: accepts stream items, range-checks requests and builds queue entries.
// Depends on rfb_pkg.
module rfb_front (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic [1:0]           orient,
   input  logic                 q_full,
   output logic                 q_push,
   output rfb_pkg::entry_type   q_entry
);

   logic [15:0]             frame_addr;
   logic [7:0]              frame_byte;
   logic [9:0]              bmp_row;
   logic [6:0]              bmp_col_byte;
   logic [rfb_pkg::CW-1:0]  height;
   logic [rfb_pkg::CW-1:0]  align_len;

   assign frame_addr   = req_tdata[15:0];
   assign frame_byte   = req_tdata[23:16];
   assign bmp_row      = req_tdata[33:24];
   assign bmp_col_byte = req_tdata[40:34];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   assign height    = rfb_pkg::logical_height(orient);
   assign align_len = orient[0] ? rfb_pkg::CW'(rfb_pkg::ALIGN_LANDSCAPE)
                                : rfb_pkg::CW'(rfb_pkg::ALIGN_PORTRAIT);

   always_comb begin
      q_entry          = '0;
      q_entry.kind     = req_tuser;
      q_entry.addr     = rfb_pkg::ADDR_W'(frame_addr);
      q_entry.data     = frame_byte;
      q_entry.wr_ok    = 32'(frame_addr) < 32'(rfb_pkg::FB_DEPTH);
      q_entry.oor      = (32'(bmp_row) >= 32'(height)) || (32'(bmp_col_byte) >= 32'(align_len));
      // BMP rows run bottom-up
      q_entry.y        = rfb_pkg::CW'(height - rfb_pkg::CW'(1) - rfb_pkg::CW'(bmp_row));
      q_entry.col_byte = bmp_col_byte;
      q_entry.orient   = orient;
   end

endmodule

// ===== rtl/rfb_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on rfb_pkg for the entry type.
module rfb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rfb_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output rfb_pkg::entry_type   head_entry
);

   rfb_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

endmodule

// ===== rtl/rfb_back.sv =====
// Back end: frame store, per-pixel rotate and fetch sequencer, result register.
// Depends on rfb_pkg.
module rfb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rfb_pkg::entry_type   head_entry,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tuser
);

   localparam int PX_W = $clog2(rfb_pkg::PANEL_WIDTH);
   localparam int PY_W = (rfb_pkg::PANEL_HEIGHT > 1) ? $clog2(rfb_pkg::PANEL_HEIGHT) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   logic [7:0] frame_mem [rfb_pkg::FB_DEPTH];

   state_type                state_ff, state_in;
   logic [2:0]               issue_ff, issue_in;
   logic [rfb_pkg::CW-1:0]   cur_y_ff, cur_y_in;
   logic [6:0]               cur_col_ff, cur_col_in;
   logic [1:0]               cur_orient_ff, cur_orient_in;
   logic [7:0]               acc_ff, acc_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_live_ff, s1_live_in;
   logic [2:0]               s1_idx_ff, s1_idx_in;
   logic [PX_W-1:0]          s1_px_ff, s1_px_in;
   logic [PY_W-1:0]          s1_py_ff, s1_py_in;

   logic                     s2_valid_ff;
   logic                     s2_live_ff;
   logic [2:0]               s2_idx_ff;
   logic [2:0]               s2_sel_ff;
   logic [7:0]               rd_data_ff;

   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff, out_byte_in;
   logic                     out_oor_ff, out_oor_in;

   logic                     out_free;
   logic                     mem_we;
   logic [rfb_pkg::ADDR_W-1:0] rd_addr;
   logic [rfb_pkg::CW-1:0]   x;
   logic [rfb_pkg::CW-1:0]   px_full;
   logic [rfb_pkg::CW-1:0]   py_full;
   logic                     pix_bit;
   logic [7:0]               acc_next;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_oor_ff;

   // Rotate the logical pixel at the current issue slot to panel coordinates
   always_comb begin
      x = rfb_pkg::CW'({cur_col_ff, issue_ff});
      case (cur_orient_ff)
         rfb_pkg::ORIENT_PORTRAIT: begin
            px_full = cur_y_ff;
            py_full = rfb_pkg::CW'(rfb_pkg::PANEL_HEIGHT - 1) - x;
         end
         rfb_pkg::ORIENT_LANDSCAPE_CW: begin
            px_full = rfb_pkg::CW'(rfb_pkg::PANEL_WIDTH - 1) - x;
            py_full = rfb_pkg::CW'(rfb_pkg::PANEL_HEIGHT - 1) - cur_y_ff;
         end
         rfb_pkg::ORIENT_PORTRAIT_INV: begin
            px_full = rfb_pkg::CW'(rfb_pkg::PANEL_WIDTH - 1) - cur_y_ff;
            py_full = x;
         end
         default: begin
            px_full = x;
            py_full = cur_y_ff;
         end
      endcase
   end

   assign rd_addr = rfb_pkg::ADDR_W'(32'(s1_py_ff) * 32'(rfb_pkg::FB_STRIDE)
                                     + 32'(s1_px_ff >> 3));

   // Black pixels clear their bit; everything else stays white
   assign pix_bit = rd_data_ff[3'd7 - s2_sel_ff];
   always_comb begin
      acc_next = acc_ff;
      if (s2_valid_ff && s2_live_ff && !pix_bit) begin
         acc_next[3'd7 - s2_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      cur_y_in      = cur_y_ff;
      cur_col_in    = cur_col_ff;
      cur_orient_in = cur_orient_ff;
      acc_in        = acc_next;
      pop           = 1'b0;
      mem_we        = 1'b0;
      s1_valid_in   = 1'b0;
      s1_live_in    = x < rfb_pkg::logical_width(cur_orient_ff);
      s1_idx_in     = issue_ff;
      s1_px_in      = PX_W'(px_full);
      s1_py_in      = PY_W'(py_full);
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_oor_in    = out_oor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_entry.kind == rfb_pkg::KIND_WRITE) begin
                  pop    = 1'b1;
                  mem_we = head_entry.wr_ok;
               end else if (out_free) begin
                  pop = 1'b1;
                  if (head_entry.oor) begin
                     out_valid_in = 1'b1;
                     out_byte_in  = rfb_pkg::WHITE_BYTE;
                     out_oor_in   = 1'b1;
                  end else begin
                     state_in      = ST_RUN;
                     issue_in      = 3'd0;
                     cur_y_in      = head_entry.y;
                     cur_col_in    = head_entry.col_byte;
                     cur_orient_in = head_entry.orient;
                     acc_in        = rfb_pkg::WHITE_BYTE;
                  end
               end
            end
         end
         ST_RUN: begin
            s1_valid_in = 1'b1;
            issue_in    = issue_ff + 3'd1;
            if (issue_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_idx_ff == 3'd7) begin
               state_in     = ST_IDLE;
               out_valid_in = 1'b1;
               out_byte_in  = acc_next;
               out_oor_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      cur_y_ff      <= cur_y_in;
      cur_col_ff    <= cur_col_in;
      cur_orient_ff <= cur_orient_in;
      acc_ff        <= acc_in;
      s1_live_ff    <= s1_live_in;
      s1_idx_ff     <= s1_idx_in;
      s1_px_ff      <= s1_px_in;
      s1_py_ff      <= s1_py_in;
      s2_live_ff    <= s1_live_ff;
      s2_idx_ff     <= s1_idx_ff;
      s2_sel_ff     <= s1_px_ff[2:0];
      out_byte_ff   <= out_byte_in;
      out_oor_ff    <= out_oor_in;
   end

   // Frame store: one write port for loads, one registered read port for fetches
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[head_entry.addr] <= head_entry.data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !s1_valid_ff && !s2_valid_ff)
      else $error("fetch pipeline busy while idle");
   a_fetch_in_store: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_live_ff |-> 32'(rd_addr) < 32'(rfb_pkg::FB_DEPTH))
      else $error("fetch address beyond frame store");
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_idx_ff == 3'd7 |=> out_valid_ff)
      else $error("finished read produced no result");
   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff)
      else $error("pending result dropped");

endmodule
